>>> sv/ifef_pkg.sv
package ifef_pkg;

  // Number of flag registers when the top level is not told otherwise.
  localparam int unsigned DefNumFlagRegs = 8;

  // Byte offset of the first enable register and size of the register window.
  localparam logic [4:0] EnableOffset = 5'h0A;
  localparam logic [4:0] WindowSize   = 5'h14;

  // Item kinds.
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_EDGE  = 2'd2,
    CMD_LEVEL = 2'd3
  } cmd_e;

  // One input item.
  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] addr;
    logic [7:0] wdata;
    logic [5:0] line;
    logic       line_level;
  } ifef_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_pending;
  } ifef_out_t;

endpackage

>>> sv/interrupt_flag_enable_fanin_core.sv
// Interrupt flag and enable register bank with pending output.
// Input channel: in_valid_i / in_stall_o carry one item (bus read, bus write,
// edge line event or level line event) per transfer in in_item_i.
// Output channel: out_valid_o / out_stall_i carry exactly one result per
// item in out_item_o: read data (zero for non-reads) and the pending flag
// as it stands after the item.
// An accepted item sits in the input register, where the register bank works
// it out and updates its state; the result is then held in the output
// register. One item is accepted in every cycle while the receiver does not
// stall; the input register and the output register set that figure.
// Reset clears all flags, held levels and enables and empties both stages.
// While the receiver stalls, the result stays in the output register, the
// next item waits in the input register, and in_stall_o rises only once
// both stages are full.
module interrupt_flag_enable_fanin_core import ifef_pkg::*; #(
  parameter int unsigned NUM_FLAG_REGS = DefNumFlagRegs
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ifef_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ifef_out_t out_item_o
);

  logic      s1_valid_q;
  logic      s1_valid_d;
  ifef_in_t  s1_item_q;
  logic      out_valid_q;
  logic      out_valid_d;
  ifef_out_t out_item_q;
  ifef_out_t res;
  logic      s1_adv;
  logic      s1_fire;
  logic      in_xfer;

  // Handshake control of the two stages.
  assign s1_adv      = ~out_valid_q | ~out_stall_i;
  assign s1_fire     = s1_valid_q & s1_adv;
  assign in_stall_o  = s1_valid_q & ~s1_adv;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_xfer | (s1_valid_q & ~s1_fire);
  assign out_valid_d = s1_fire | (out_valid_q & out_stall_i);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item_i;
    end
  end

  // Flag, held-level and enable state with its update logic.
  ifef_regbank #(
    .NUM_FLAG_REGS(NUM_FLAG_REGS)
  ) u_regbank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (s1_fire),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The input side is only held off while an item waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // An item that leaves the input register always appears as a result.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("completed item produced no result");

  // An item that is accepted always lands in the input register.
  a_xfer_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("accepted item lost before the input register");

endmodule

>>> sv/ifef_regbank.sv
module ifef_regbank import ifef_pkg::*; #(
  parameter int unsigned NUM_FLAG_REGS = DefNumFlagRegs
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  ifef_in_t  item_i,
  output ifef_out_t res_o
);

  logic [7:0] latched_q [NUM_FLAG_REGS];
  logic [7:0] latched_d [NUM_FLAG_REGS];
  logic [7:0] held_q    [NUM_FLAG_REGS];
  logic [7:0] held_d    [NUM_FLAG_REGS];
  logic [7:0] en_q      [NUM_FLAG_REGS];
  logic [7:0] en_d      [NUM_FLAG_REGS];
  logic [7:0] rd_part   [NUM_FLAG_REGS];
  logic [NUM_FLAG_REGS-1:0] pend_part;

  logic [7:0] line_bit;

  // Decode the bit within a flag register that a line event addresses.
  assign line_bit = 8'(1) << item_i.line[2:0];

  for (genvar r = 0; r < NUM_FLAG_REGS; r++) begin : g_reg
    logic flag_hit;
    logic en_hit;
    logic line_hit;

    assign flag_hit = (item_i.addr == 5'(r));
    assign en_hit   = (item_i.addr == EnableOffset + 5'(r)) && (item_i.addr < WindowSize);
    assign line_hit = (item_i.line[5:3] == 3'(r));

    // Next state of this register's flags and enables for the current item.
    always_comb begin
      latched_d[r] = latched_q[r];
      held_d[r]    = held_q[r];
      en_d[r]      = en_q[r];
      rd_part[r]   = 8'h00;
      unique case (item_i.cmd)
        CMD_READ: begin
          if (flag_hit) begin
            rd_part[r] = latched_q[r] | held_q[r];
          end else if (en_hit) begin
            rd_part[r] = en_q[r];
          end
        end
        CMD_WRITE: begin
          if (flag_hit) begin
            latched_d[r] = item_i.wdata & ~held_q[r];
          end else if (en_hit) begin
            en_d[r] = item_i.wdata;
          end
        end
        CMD_EDGE: begin
          if (line_hit && item_i.line_level) begin
            latched_d[r] = latched_q[r] | line_bit;
          end
        end
        CMD_LEVEL: begin
          if (line_hit) begin
            if (item_i.line_level) begin
              held_d[r] = held_q[r] | line_bit;
            end else begin
              held_d[r] = held_q[r] & ~line_bit;
            end
          end
        end
        default: ;
      endcase
    end

    // A register asks for service when any enabled flag is set after the item.
    assign pend_part[r] = |((latched_d[r] | held_d[r]) & en_d[r]);

    // State registers change only when the item completes.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        latched_q[r] <= 8'h00;
        held_q[r]    <= 8'h00;
        en_q[r]      <= 8'h00;
      end else if (go_i) begin
        latched_q[r] <= latched_d[r];
        held_q[r]    <= held_d[r];
        en_q[r]      <= en_d[r];
      end
    end
  end

  // At most one register matches a read, so the read data is an OR of the parts.
  always_comb begin
    res_o.rdata = 8'h00;
    for (int unsigned r = 0; r < NUM_FLAG_REGS; r++) begin
      res_o.rdata = res_o.rdata | rd_part[r];
    end
    res_o.irq_pending = |pend_part;
  end

endmodule

>>> sim/interrupt_flag_enable_fanin_core_tb.sv
module interrupt_flag_enable_fanin_core_tb;
  import ifef_pkg::*;

  localparam int unsigned NumRegs    = DefNumFlagRegs;
  localparam int          HalfPeriod = 6;
  localparam int          NumRandom  = 500;
  localparam int          IdlePct    = 19;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  ifef_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ifef_out_t out_item;

  // When set, neither side inserts idle cycles.
  bit        calm = 1'b0;

  // Hand-written expectation for the item currently offered, if any.
  bit        offer_typed = 1'b0;
  ifef_out_t offer_result = '0;

  // Shadow of the flag and enable bank.
  logic [7:0] latched_q [NumRegs];
  logic [7:0] held_q    [NumRegs];
  logic [7:0] enable_q  [NumRegs];

  ifef_out_t readback_q [$];

  int unsigned error_count   = 0;
  int unsigned item_count    = 0;
  int unsigned result_count  = 0;
  int unsigned read_count    = 0;
  int unsigned pending_count = 0;
  int unsigned directed_rows = 0;

  // One row of the directed stimulus table.
  typedef struct {
    ifef_in_t  item;
    bit        typed;
    ifef_out_t result;
  } dir_row_t;

  dir_row_t dir_table [$];

  interrupt_flag_enable_fanin_core #(
    .NUM_FLAG_REGS(NumRegs)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #HalfPeriod clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Applies one item to the shadow bank and returns the result it produces.
  function automatic ifef_out_t apply_irq_item(input ifef_in_t it);
    ifef_out_t   res;
    int unsigned reg_idx;
    int unsigned en_idx;
    logic [7:0]  bit_mask;
    logic        flag_hit;
    logic        en_hit;
    res      = '0;
    reg_idx  = int'(it.line) >> 3;
    bit_mask = 8'h01 << it.line[2:0];
    flag_hit = int'(it.addr) < NumRegs;
    en_hit   = (it.addr >= EnableOffset) && (it.addr < WindowSize) &&
               (int'(it.addr) - int'(EnableOffset) < NumRegs);
    en_idx   = en_hit ? int'(it.addr) - int'(EnableOffset) : 0;
    case (it.cmd)
      CMD_READ: begin
        if (flag_hit) res.rdata = latched_q[it.addr] | held_q[it.addr];
        else if (en_hit) res.rdata = enable_q[en_idx];
      end
      CMD_WRITE: begin
        // Bits held by a level line cannot be cleared or set by software.
        if (flag_hit) latched_q[it.addr] = it.wdata & ~held_q[it.addr];
        else if (en_hit) enable_q[en_idx] = it.wdata;
      end
      CMD_EDGE: begin
        if (it.line_level && reg_idx < NumRegs) latched_q[reg_idx] |= bit_mask;
      end
      default: begin
        if (reg_idx < NumRegs) begin
          if (it.line_level) held_q[reg_idx] |= bit_mask;
          else held_q[reg_idx] &= ~bit_mask;
        end
      end
    endcase
    for (int r = 0; r < NumRegs; r++) begin
      if (((latched_q[r] | held_q[r]) & enable_q[r]) != 8'h00) res.irq_pending = 1'b1;
    end
    return res;
  endfunction

  // Predict on every input transfer, then check every output transfer.
  always @(posedge clk) begin
    ifef_out_t predicted;
    ifef_out_t want;
    ifef_out_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = apply_irq_item(in_item);
        readback_q.push_back(offer_typed ? offer_result : predicted);
        item_count++;
        if (in_item.cmd == CMD_READ) read_count++;
      end
      if (out_valid && !out_stall) begin
        got = out_item;
        result_count++;
        if (got.irq_pending) pending_count++;
        if (readback_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding, rdata=%02h pend=%0b",
                                    got.rdata, got.irq_pending));
        end else begin
          want = readback_q.pop_front();
          if (got.rdata !== want.rdata)
            report_mismatch($sformatf("rdata %02h, expected %02h", got.rdata, want.rdata));
          if (got.irq_pending !== want.irq_pending)
            report_mismatch($sformatf("irq_pending %0b, expected %0b",
                                      got.irq_pending, want.irq_pending));
        end
      end
    end
  end

  // Receiver stalls at random outside the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  // Offers one item, with a random gap first, and waits for its transfer.
  task automatic send_item(input ifef_in_t it, input bit typed, input ifef_out_t res);
    while (!calm && ($urandom_range(0, 99) < IdlePct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item      <= it;
    in_valid     <= 1'b1;
    offer_typed  = typed;
    offer_result = res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic add_row(input cmd_e cmd, input logic [4:0] addr, input logic [7:0] wdata,
                         input logic [5:0] line, input logic lvl, input bit typed,
                         input logic [7:0] rdata, input logic pend);
    dir_row_t row;
    row.item.cmd        = cmd;
    row.item.addr       = addr;
    row.item.wdata      = wdata;
    row.item.line       = line;
    row.item.line_level = lvl;
    row.typed           = typed;
    row.result.rdata    = rdata;
    row.result.irq_pending = pend;
    dir_table.push_back(row);
  endtask

  function automatic ifef_in_t random_item();
    ifef_in_t    it;
    int unsigned pick;
    it.cmd = cmd_e'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    it.addr = (pick < 85) ? 5'($urandom_range(0, 19)) : 5'($urandom_range(20, 31));
    // Zero writes keep flags and enables clearing, so pending falls as well as rises.
    pick = $urandom_range(0, 99);
    it.wdata = (pick < 25) ? 8'h00 : (pick < 35) ? 8'hFF : 8'($urandom);
    it.line = 6'($urandom_range(0, 63));
    it.line_level = 1'($urandom_range(0, 1));
    return it;
  endfunction

  initial begin
    for (int r = 0; r < NumRegs; r++) begin
      latched_q[r] = '0;
      held_q[r]    = '0;
      enable_q[r]  = '0;
    end

    // Directed table: reset values, window edges, then the flag special cases.
    add_row(CMD_READ,  5'd0,  8'h00, 6'd0,  1'b0, 1'b1, 8'h00, 1'b0);
    add_row(CMD_READ,  5'd10, 8'h00, 6'd0,  1'b0, 1'b1, 8'h00, 1'b0);
    add_row(CMD_READ,  5'd9,  8'hFF, 6'd63, 1'b1, 1'b1, 8'h00, 1'b0);
    add_row(CMD_READ,  5'd31, 8'h00, 6'd0,  1'b0, 1'b1, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd0,  8'hFF, 6'd0,  1'b0, 1'b1, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd17, 8'hFF, 6'd0,  1'b0, 1'b1, 8'h00, 1'b0);
    add_row(CMD_EDGE,  5'd0,  8'h00, 6'd63, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_EDGE,  5'd0,  8'h00, 6'd63, 1'b1, 1'b1, 8'h00, 1'b1);
    add_row(CMD_READ,  5'd7,  8'h00, 6'd0,  1'b0, 1'b1, 8'h80, 1'b1);
    add_row(CMD_LEVEL, 5'd0,  8'h00, 6'd56, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd7,  8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_READ,  5'd7,  8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd7,  8'hFF, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_LEVEL, 5'd0,  8'h00, 6'd56, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd7,  8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_LEVEL, 5'd0,  8'h00, 6'd5,  1'b1, 1'b0, 8'h00, 1'b0);
    add_row(CMD_EDGE,  5'd0,  8'h00, 6'd5,  1'b1, 1'b0, 8'h00, 1'b0);
    add_row(CMD_LEVEL, 5'd0,  8'h00, 6'd5,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd10, 8'h20, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_READ,  5'd0,  8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd19, 8'hAA, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd8,  8'h55, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd31, 8'hFF, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_READ,  5'd17, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    add_row(CMD_WRITE, 5'd0,  8'h00, 6'd0,  1'b0, 1'b0, 8'h00, 1'b0);
    directed_rows = dir_table.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].result);

    // Random part, with a stretch in the middle where neither side idles.
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 150) && (n < 300);
      send_item(random_item(), 1'b0, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then idle on so that any stray transfer can show.
    while (readback_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d items (%0d directed, %0d bus reads) and %0d results,",
             item_count, directed_rows, read_count, result_count);
    $display("with the pending output high on %0d of them.", pending_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(2 * HalfPeriod * 300000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
